// ===== rtl/core/asgd_pkg.sv =====
`default_nettype none
package asgd_pkg;

  localparam int DEF_ELEMENT_COUNT = 4096;
  localparam int DEF_VALUE_WIDTH   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 3'd4;

  localparam logic        MODE_SGD  = 1'b0;
  localparam logic        MODE_ADAM = 1'b1;
  localparam logic [23:0] RST_LEARNING_RATE = 24'd16777;
  localparam logic [15:0] RST_BETA_ONE      = 16'd58982;
  localparam logic [15:0] RST_BETA_TWO      = 16'd65470;
  localparam logic [23:0] RST_EPSILON       = 24'd1;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 34;
  localparam int SQRT_W    = 64;

  typedef struct packed {
    logic [11:0]        element_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
    logic               starts_call;
  } in_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic [11:0]        index_out;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [SQRT_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/adam_sgd_weight_update_core.sv =====
// Optimizer weight update, SGD or Adam, on signed Q8.24 values. One element is
// worked at a time: in_ready stays low from acceptance until the result is in
// the output register. Adam time is set by three runs of the shared
// shift-subtract divider (two bias corrections and the final quotient) and
// the run of the root unit. The index is reduced by a reciprocal
// multiplication. A stalled result stays in the output register; the next
// result waits in the last state until the stalled one is taken.
// After reset the moment stores are swept to zero, during which no element is
// taken; configuration writes are taken at any time.
`default_nettype none
module adam_sgd_weight_update_core
  import asgd_pkg::*;
#(
  parameter int ELEMENT_COUNT = DEF_ELEMENT_COUNT,
  parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW       = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam int SAT_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic signed [63:0] SAT_MAX   = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_MIN   = -SAT_MAX - 64'sd1;
  localparam logic [63:0]        SAT_MAX_U = SAT_MAX;
  localparam logic [63:0]        STEP_CAP  = 64'h100_0000_0000;
  localparam int                 MOD_RECIP_I = (16777216 + ELEMENT_COUNT - 1) / ELEMENT_COUNT;
  localparam logic [35:0]        MOD_RECIP = 36'(MOD_RECIP_I);
  localparam logic [31:0]        ELEM_N    = 32'(ELEMENT_COUNT);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MOD    = 12'b0000_0000_0010,
    S_READ   = 12'b0000_0000_0100,
    S_MOM1   = 12'b0000_0000_1000,
    S_MOM2   = 12'b0000_0001_0000,
    S_MOM3   = 12'b0000_0010_0000,
    S_DIVM   = 12'b0000_0100_0000,
    S_DIVV   = 12'b0000_1000_0000,
    S_SQRT   = 12'b0001_0000_0000,
    S_DIVQ   = 12'b0010_0000_0000,
    S_SCALE1 = 12'b0100_0000_0000,
    S_SCALE2 = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic        mode_r;
  logic [23:0] lr_r, eps_r;
  logic [15:0] b1_r, b2_r;

  logic [31:0] step_r, pw1_r, pw2_r;

  logic signed [31:0] w_r, g_r, m_new_r;
  logic               sc_r, neg_r, flag_r;
  logic [11:0]        idx_r;
  logic [AW-1:0]      addr_r;
  logic [35:0]        mod_prod_r;
  logic signed [49:0] pm1_r, pm2_r;
  logic [63:0]        pgg_r;
  logic [47:0]        pv1_r;
  logic [56:0]        pv2_r;
  logic [31:0]        mm_r, v_new_r, mh_r;
  logic [55:0]        mag_r, ph_r;
  logic [47:0]        pl_r;

  logic  out_valid_r;
  out_t  out_r;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  logic        mem_rd, mem_wr, clr_busy;
  logic [31:0] rd_m, rd_v;

  logic [47:0]        pw1_prod, pw2_prod;
  logic [16:0]        b1c, b2c;
  logic [31:0]        gm;
  logic [39:0]        g2;
  logic signed [63:0] ms, mf, mc;
  logic [63:0]        vs, vc, mhc, vhc, dlo, dsum, dcap;
  logic [33:0]        qden;
  logic signed [63:0] res, resc;
  logic               in_acc, out_load;
  logic [11:0]        mod_q;
  logic [31:0]        mod_rem;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !clr_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ADAM;
      lr_r   <= RST_LEARNING_RATE;
      b1_r   <= RST_BETA_ONE;
      b2_r   <= RST_BETA_TWO;
      eps_r  <= RST_EPSILON;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:          mode_r <= cfg_data[0];
        CFG_LEARNING_RATE: lr_r   <= cfg_data;
        CFG_BETA_ONE:      b1_r   <= cfg_data[15:0];
        CFG_BETA_TWO:      b2_r   <= cfg_data[15:0];
        CFG_EPSILON:       eps_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // index modulo element count: the reciprocal quotient is exact for 12-bit indexes
  assign mod_q   = mod_prod_r[35:24];
  assign mod_rem = 32'(idx_r) - 32'(mod_q) * ELEM_N;

  // datapath arithmetic
  assign pw1_prod = pw1_r * b1_r;
  assign pw2_prod = pw2_r * b2_r;
  assign b1c      = 17'h1_0000 - 17'(b1_r);
  assign b2c      = 17'h1_0000 - 17'(b2_r);
  assign gm       = g_r[31] ? 32'(-g_r) : 32'(g_r);
  assign g2       = 40'((pgg_r + 64'h80_0000) >> 24);

  assign ms = 64'(pm1_r) + 64'(pm2_r) + 64'sd32768;
  assign mf = ms >>> 16;
  assign mc = (mf > SAT_MAX) ? SAT_MAX : ((mf < SAT_MIN) ? SAT_MIN : mf);

  assign vs = (64'(pv1_r) + 64'(pv2_r) + 64'd32768) >> 16;
  assign vc = (vs > SAT_MAX_U) ? SAT_MAX_U : vs;

  assign mhc = (div_rsp.quo > SAT_MAX_U) ? SAT_MAX_U : div_rsp.quo;
  assign vhc = mhc;

  assign qden = (34'(sq_rsp.root) + 34'(eps_r) == 34'd0) ?
                34'd1 : 34'(sq_rsp.root) + 34'(eps_r);

  assign dlo  = (64'(pl_r) + 64'h80_0000) >> 24;
  assign dsum = 64'(ph_r) + dlo;
  assign dcap = (dsum > STEP_CAP) ? STEP_CAP : dsum;
  assign res  = neg_r ? 64'(w_r) + $signed(dcap) : 64'(w_r) - $signed(dcap);
  assign resc = (res > SAT_MAX) ? SAT_MAX : ((res < SAT_MIN) ? SAT_MIN : res);

  assign out_load = (state_r == S_SCALE2) && (!out_valid_r || out_ready);

  // shared divider and root unit requests
  always_comb begin
    div_req       = '0;
    sq_req        = '0;
    case (state_r)
      S_MOM3: begin
        div_req.start = 1'b1;
        div_req.num   = {mm_r, 32'd0};
        div_req.den   = 34'h1_0000_0000 - 34'(pw1_r);
      end
      S_DIVM: begin
        div_req.start = div_rsp.done;
        div_req.num   = {v_new_r, 32'd0};
        div_req.den   = 34'h1_0000_0000 - 34'(pw2_r);
      end
      S_DIVV: begin
        sq_req.start    = div_rsp.done;
        sq_req.radicand = {vhc[39:0], 24'd0};
      end
      S_SQRT: begin
        div_req.start = sq_rsp.done;
        div_req.num   = {8'd0, mh_r, 24'd0};
        div_req.den   = qden;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_MOD;
      S_MOD:    state_nxt = mode_r ? S_READ : S_SCALE1;
      S_READ: begin
        mem_rd    = 1'b1;
        state_nxt = S_MOM1;
      end
      S_MOM1:   state_nxt = S_MOM2;
      S_MOM2:   state_nxt = S_MOM3;
      S_MOM3: begin
        mem_wr    = 1'b1;
        state_nxt = S_DIVM;
      end
      S_DIVM:   if (div_rsp.done) state_nxt = S_DIVV;
      S_DIVV:   if (div_rsp.done) state_nxt = S_SQRT;
      S_SQRT:   if (sq_rsp.done) state_nxt = S_DIVQ;
      S_DIVQ:   if (div_rsp.done) state_nxt = S_SCALE1;
      S_SCALE1: state_nxt = S_SCALE2;
      S_SCALE2: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      pw1_r       <= '1;
      pw2_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_READ && sc_r) begin
        if (step_r != '1)
          step_r <= step_r + 32'd1;
        pw1_r <= pw1_prod[47:16];
        pw2_r <= pw2_prod[47:16];
      end
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          w_r        <= in_data.weight_in;
          g_r        <= in_data.gradient;
          sc_r       <= in_data.starts_call;
          flag_r     <= 1'b0;
          idx_r      <= in_data.element_index;
          mod_prod_r <= 36'(in_data.element_index) * MOD_RECIP;
        end
      end
      S_MOD: begin
        idx_r  <= mod_rem[11:0];
        addr_r <= mod_rem[AW-1:0];
        neg_r  <= g_r[31];
        mag_r  <= 56'(gm);
      end
      S_MOM1: begin
        pm1_r <= $signed({1'b0, b1_r}) * $signed(rd_m);
        pm2_r <= $signed({1'b0, b1c}) * g_r;
        pgg_r <= gm * gm;
        pv1_r <= b2_r * rd_v;
      end
      S_MOM2: begin
        pv2_r   <= b2c * g2;
        m_new_r <= 32'(mc);
        neg_r   <= mc[63];
        mm_r    <= mc[63] ? 32'(-mc) : 32'(mc);
        if (mc != mf) flag_r <= 1'b1;
      end
      S_MOM3: begin
        v_new_r <= 32'(vc);
        if (vc != vs) flag_r <= 1'b1;
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          mh_r <= 32'(mhc);
          if (mhc != div_rsp.quo) flag_r <= 1'b1;
        end
      end
      S_DIVV: begin
        if (div_rsp.done && vhc != div_rsp.quo) flag_r <= 1'b1;
      end
      S_DIVQ: begin
        if (div_rsp.done) mag_r <= div_rsp.quo[55:0];
      end
      S_SCALE1: begin
        ph_r <= lr_r * mag_r[55:24];
        pl_r <= lr_r * mag_r[23:0];
      end
      S_SCALE2: begin
        if (out_load) begin
          out_r.weight_out <= 32'(resc);
          out_r.index_out  <= idx_r;
          out_r.saturated  <= flag_r || (resc != res);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  asgd_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  asgd_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .rsp  (sq_rsp)
  );

  asgd_moment_mem #(
    .ELEMENT_COUNT(ELEMENT_COUNT),
    .AW           (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd),
    .rd_addr  (addr_r),
    .wr_en    (mem_wr),
    .wr_addr  (addr_r),
    .wr_first (m_new_r),
    .wr_second(32'(vc)),
    .rd_first (rd_m),
    .rd_second(rd_v),
    .clr_busy (clr_busy)
  );

endmodule
`default_nettype wire

// ===== rtl/core/asgd_divider.sv =====
`default_nettype none
module asgd_divider
  import asgd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, done_r;
  logic [5:0]           cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // shift one numerator bit into the partial remainder per cycle
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end else if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/asgd_sqrt.sv =====
`default_nettype none
module asgd_sqrt
  import asgd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  logic              busy_r, done_r;
  logic [4:0]        cnt_r;
  logic [SQRT_W-1:0] x_r, res_r, bit_r, sum;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end
    end
  end

  // two radicand bits per cycle, one root bit
  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (x_r >= sum) begin
        x_r   <= x_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end else if (req.start) begin
      x_r   <= req.radicand;
      res_r <= '0;
      bit_r <= {2'b01, {(SQRT_W-2){1'b0}}};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];

endmodule
`default_nettype wire

// ===== rtl/core/asgd_moment_mem.sv =====
`default_nettype none
module asgd_moment_mem
  import asgd_pkg::*;
#(
  parameter int ELEMENT_COUNT = DEF_ELEMENT_COUNT,
  parameter int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_first,
  input  wire logic [31:0]   wr_second,
  output logic [31:0]        rd_first,
  output logic [31:0]        rd_second,
  output logic               clr_busy
);

  logic [31:0]   first_mem  [ELEMENT_COUNT];
  logic [31:0]   second_mem [ELEMENT_COUNT];
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          we;
  logic [AW-1:0] waddr;

  assign we    = clr_busy_r || wr_en;
  assign waddr = clr_busy_r ? clr_addr_r : wr_addr;

  // sweep zeros through both stores after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(ELEMENT_COUNT - 1))
        clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      first_mem[waddr]  <= clr_busy_r ? 32'd0 : wr_first;
      second_mem[waddr] <= clr_busy_r ? 32'd0 : wr_second;
    end
    if (rd_en) begin
      rd_first  <= first_mem[rd_addr];
      rd_second <= second_mem[rd_addr];
    end
  end

  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

// ===== rtl/core/asgd_checker.sv =====
`default_nettype none
module asgd_checker
  import asgd_pkg::*;
#(
  parameter int ELEMENT_COUNT = DEF_ELEMENT_COUNT
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.index_out) < 32'(ELEMENT_COUNT)))
    else $error("index beyond element count");

endmodule

bind adam_sgd_weight_update_core asgd_checker #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
